FILE: rtl/core/servo_status_packet_checker_macros.svh
// Assertion macros for the servo status packet checker.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef SERVO_STATUS_PACKET_CHECKER_MACROS_SVH
`define SERVO_STATUS_PACKET_CHECKER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define SPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define SPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/spc_pkg.sv
// Shared types and constants of the servo status packet checker.
// No dependencies; used by every module in rtl/core.
package spc_pkg;

  // Operation codes carried on in_tuser
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Verdict codes
  localparam logic [2:0] VERDICT_OK       = 3'd0;
  localparam logic [2:0] VERDICT_HEADER   = 3'd1;
  localparam logic [2:0] VERDICT_ID       = 3'd2;
  localparam logic [2:0] VERDICT_LENGTH   = 3'd3;
  localparam logic [2:0] VERDICT_CHECKSUM = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_ID     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_LIMIT   = 2'd2;

  // Protocol constants
  localparam logic [7:0]  BROADCAST_ID  = 8'hFE;
  localparam logic [7:0]  HEADER_BYTE   = 8'hFF;
  localparam logic [7:0]  SUM_GOOD      = 8'hFF;
  localparam logic [7:0]  OPEN_LENGTH   = 8'hFF;
  localparam logic [7:0]  MAX_COUNT     = 8'hFF;
  localparam logic [7:0]  MIN_CHECKED   = 8'd3;
  localparam logic [7:0]  FRAME_OVERHEAD = 8'd4;

  // Reset values of the configuration registers
  localparam logic [7:0]  RST_EXPECTED_ID     = 8'd254;
  localparam logic [7:0]  RST_EXPECTED_LENGTH = 8'd6;
  localparam logic [15:0] RST_TIMEOUT_LIMIT   = 16'd30000;

  localparam int unsigned OUT_TDATA_W = 24;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
  } in_item_t;

  // Packed so that received_length lands in the lowest bits
  typedef struct packed {
    logic       flush_request;
    logic       timed_out;
    logic [7:0] return_length;
    logic [2:0] verdict;
    logic [7:0] received_length;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

endpackage

FILE: rtl/core/spc_in_reg.sv
// Input register of the servo status packet checker.
// Depends on spc_pkg for the request type.
module spc_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // rx_byte[7:0]
  input  logic [1:0]        in_tuser,   // operation[1:0]
  input  logic              advance,
  output logic              item_valid,
  output spc_pkg::in_item_t item
);

  logic              valid_r, valid_nxt;
  spc_pkg::in_item_t item_r;
  logic              load;

  // Take a new request whenever the held one moves on this cycle
  assign in_tready = !valid_r || advance;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload: no reset
  always_ff @(posedge clk) begin
    if (load) begin
      item_r.operation <= in_tuser;
      item_r.rx_byte   <= in_tdata;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: rtl/core/spc_core.sv
// Packet state, configuration registers and verdict logic of the checker.
// Depends on spc_pkg for codes, constants and types.
module spc_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [spc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            step,
  input  spc_pkg::in_item_t               item,
  output logic                            res_valid,
  output spc_pkg::result_t                res
);

  // Configuration
  logic [7:0]  expected_id_r;
  logic [7:0]  expected_length_r;
  logic [15:0] timeout_limit_r;

  // Packet state
  logic        receiving_r, receiving_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic        header_good_r, header_good_nxt;
  logic        id_good_r, id_good_nxt;
  logic [7:0]  length_field_r, length_field_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic [15:0] idle_ticks_r, idle_ticks_nxt;

  // Updated state before the end-of-packet clear
  logic        upd_receiving;
  logic [7:0]  upd_count;
  logic        upd_header_good;
  logic        upd_id_good;
  logic [7:0]  upd_length_field;
  logic [7:0]  upd_sum;
  logic [15:0] upd_idle;
  logic        fin;
  logic        fin_tmo;

  logic        checked;
  logic [2:0]  verdict;
  logic        flush;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_id_r     <= spc_pkg::RST_EXPECTED_ID;
      expected_length_r <= spc_pkg::RST_EXPECTED_LENGTH;
      timeout_limit_r   <= spc_pkg::RST_TIMEOUT_LIMIT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        spc_pkg::CFG_EXPECTED_ID:     expected_id_r     <= cfg_wdata[7:0];
        spc_pkg::CFG_EXPECTED_LENGTH: expected_length_r <= cfg_wdata[7:0];
        spc_pkg::CFG_TIMEOUT_LIMIT:   timeout_limit_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance the packet state by one request
  always_comb begin
    upd_receiving    = receiving_r;
    upd_count        = byte_count_r;
    upd_header_good  = header_good_r;
    upd_id_good      = id_good_r;
    upd_length_field = length_field_r;
    upd_sum          = running_sum_r;
    upd_idle         = idle_ticks_r;
    fin              = 1'b0;
    fin_tmo          = 1'b0;
    case (item.operation)
      spc_pkg::OP_START: begin
        upd_receiving    = 1'b1;
        upd_count        = 8'd0;
        upd_header_good  = 1'b1;
        upd_id_good      = 1'b1;
        upd_length_field = 8'd0;
        upd_sum          = 8'd0;
        upd_idle         = 16'd0;
        fin              = (expected_length_r == 8'd0);
      end
      spc_pkg::OP_BYTE: begin
        if (receiving_r) begin
          upd_idle = 16'd0;
          if (byte_count_r < 8'd2) begin
            if (item.rx_byte != spc_pkg::HEADER_BYTE) begin
              upd_header_good = 1'b0;
            end
          end else begin
            if (byte_count_r == 8'd2 && item.rx_byte != expected_id_r) begin
              upd_id_good = 1'b0;
            end
            if (byte_count_r == 8'd3) begin
              upd_length_field = item.rx_byte;
            end
            upd_sum = running_sum_r + item.rx_byte;
          end
          if (byte_count_r != spc_pkg::MAX_COUNT) begin
            upd_count = byte_count_r + 8'd1;
          end
          fin = (upd_count >= expected_length_r);
        end
      end
      spc_pkg::OP_TICK: begin
        if (receiving_r) begin
          if (idle_ticks_r >= timeout_limit_r) begin
            fin     = 1'b1;
            fin_tmo = 1'b1;
          end else begin
            upd_idle = idle_ticks_r + 16'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // Judge the packet; first failing check wins
  always_comb begin
    checked = (expected_id_r != spc_pkg::BROADCAST_ID);
    verdict = spc_pkg::VERDICT_OK;
    if (checked && upd_count > spc_pkg::MIN_CHECKED) begin
      if (!upd_header_good) begin
        verdict = spc_pkg::VERDICT_HEADER;
      end else if (!upd_id_good) begin
        verdict = spc_pkg::VERDICT_ID;
      end else if (upd_length_field != upd_count - spc_pkg::FRAME_OVERHEAD) begin
        verdict = spc_pkg::VERDICT_LENGTH;
      end else if (upd_sum != spc_pkg::SUM_GOOD) begin
        verdict = spc_pkg::VERDICT_CHECKSUM;
      end
    end
    flush = checked && ((fin_tmo && expected_length_r != spc_pkg::OPEN_LENGTH)
                        || verdict != spc_pkg::VERDICT_OK);
  end

  assign res_valid           = step && fin;
  assign res.received_length = upd_count;
  assign res.verdict         = verdict;
  assign res.return_length   = (verdict == spc_pkg::VERDICT_OK) ? upd_count : 8'd0;
  assign res.timed_out       = fin_tmo;
  assign res.flush_request   = flush;

  // Commit the update, or clear the packet once it ends
  always_comb begin
    receiving_nxt    = receiving_r;
    byte_count_nxt   = byte_count_r;
    header_good_nxt  = header_good_r;
    id_good_nxt      = id_good_r;
    length_field_nxt = length_field_r;
    running_sum_nxt  = running_sum_r;
    idle_ticks_nxt   = idle_ticks_r;
    if (step) begin
      if (fin) begin
        receiving_nxt    = 1'b0;
        byte_count_nxt   = 8'd0;
        header_good_nxt  = 1'b1;
        id_good_nxt      = 1'b1;
        length_field_nxt = 8'd0;
        running_sum_nxt  = 8'd0;
        idle_ticks_nxt   = 16'd0;
      end else begin
        receiving_nxt    = upd_receiving;
        byte_count_nxt   = upd_count;
        header_good_nxt  = upd_header_good;
        id_good_nxt      = upd_id_good;
        length_field_nxt = upd_length_field;
        running_sum_nxt  = upd_sum;
        idle_ticks_nxt   = upd_idle;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r    <= 1'b0;
      byte_count_r   <= 8'd0;
      header_good_r  <= 1'b1;
      id_good_r      <= 1'b1;
      length_field_r <= 8'd0;
      running_sum_r  <= 8'd0;
      idle_ticks_r   <= 16'd0;
    end else begin
      receiving_r    <= receiving_nxt;
      byte_count_r   <= byte_count_nxt;
      header_good_r  <= header_good_nxt;
      id_good_r      <= id_good_nxt;
      length_field_r <= length_field_nxt;
      running_sum_r  <= running_sum_nxt;
      idle_ticks_r   <= idle_ticks_nxt;
    end
  end

endmodule

FILE: rtl/core/spc_out_reg.sv
// Result register of the servo status packet checker.
// Depends on spc_pkg for the result type and output width.
module spc_out_reg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            res_load,
  input  spc_pkg::result_t                res,
  output logic                            advance,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // received_length[7:0], verdict[10:8], return_length[18:11],
  // timed_out[19], flush_request[20], zero[23:21]
  output logic [spc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic             valid_r, valid_nxt;
  spc_pkg::result_t res_r;

  // Free for a new result when empty or being drained now
  assign advance = !valid_r || out_tready;

  always_comb begin
    if (res_load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(spc_pkg::OUT_TDATA_W - spc_pkg::RESULT_W){1'b0}}, res_r};

endmodule

FILE: rtl/core/servo_status_packet_checker.sv
// Servo status packet checker. Each request (start, received byte or time
// tick) is registered on entry, judged combinationally against the packet
// state and, when it ends a packet, leaves its result in an output register
// once that is free. One request is taken every clock cycle; the rate
// is set by the input register and the result register, and a result that
// waits on out_tready stalls the input stage only when both are full.
// Configuration writes go straight to the registers and apply to the next
// request judged.
// Depends on spc_pkg, spc_in_reg, spc_core, spc_out_reg and the macro header.
`include "servo_status_packet_checker_macros.svh"

module servo_status_packet_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // rx_byte[7:0]
  input  logic [1:0]                      in_tuser,   // operation[1:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // received_length[7:0], verdict[10:8], return_length[18:11],
  // timed_out[19], flush_request[20], zero[23:21]
  output logic [spc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [spc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic              item_valid;
  spc_pkg::in_item_t item;
  logic              advance;
  logic              step;
  logic              res_valid;
  spc_pkg::result_t  res;
  spc_pkg::result_t  out_res;
  logic              out_fail;
  logic              out_empty;
  logic              fail_marked;
  logic              out_blocked;

  assign step    = item_valid && advance;
  assign out_res = out_tdata[spc_pkg::RESULT_W-1:0];

  spc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  spc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  spc_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_load   (res_valid),
    .res        (res),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Terms of the held result for the checks below
  assign out_fail    = out_res.verdict != spc_pkg::VERDICT_OK;
  assign out_empty   = out_res.received_length == 8'd0;
  assign fail_marked = out_res.return_length == 8'd0 && out_res.flush_request;
  assign out_blocked = out_tvalid && !out_tready;

  // Failed checks always zero the returned length and ask for a flush
  `SPC_ASSERT_IMP(a_fail_flush, out_tvalid && out_fail, fail_marked, "failed verdict not marked")
  // An empty packet never carries a failing verdict
  `SPC_ASSERT_IMP(a_empty_ok, out_tvalid && out_empty, !out_fail, "empty packet failing")
  // Input stalls only when both stages are full and the output is blocked
  `SPC_ASSERT_IMP(a_stall_cause, !in_tready, item_valid && out_blocked, "unexplained input stall")
  // A stalled result is not overwritten by a new one
  `SPC_ASSERT_NXT(a_no_overwrite, out_blocked, !$past(res_valid && step), "result overwritten")

endmodule
